@@ rtl/lhm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and constants of the latency histogram monitor.
package lhm_pkg;

  // Fixed field widths of the request and result beats.
  localparam int unsigned SEL_W     = 2;
  localparam int unsigned NS_W      = 40;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned OUT_CNT_W = 32;
  localparam int unsigned TOTAL_W   = 64;
  localparam int unsigned MAX_W     = 40;
  localparam int unsigned PERC_W    = 35;

  // Defaults for the top-level parameters.
  localparam int unsigned NUM_COUNTERS_DEF = 4;
  localparam int unsigned NUM_BUCKETS_DEF  = 35;
  localparam int unsigned COUNT_WIDTH_DEF  = 32;

  // The shared unit is wide enough for a 64-bit count times a 7-bit percent.
  localparam int unsigned ALU_W = 72;

  // Percentile test: seen >= ceil(count * percent / 100) holds exactly when
  // seen * 100 >= count * percent, with 100 built as 2^6 + 2^5 + 2^2.
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam int unsigned      SCALE_SH0 = 6;
  localparam int unsigned      SCALE_SH1 = 5;
  localparam int unsigned      SCALE_SH2 = 2;

  // Request codes.
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Operations of the shared adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Result of the shared adder: value, and the a >= b flag for a subtract or the saturation flag for an add.
  typedef struct packed {
    logic [ALU_W-1:0] value;
    logic             ge;
  } alu_res_t;

endpackage

@@ rtl/lhm_alu.sv @@
`timescale 1ns / 1ps
// Shared saturating adder and subtract-compare unit of the monitor.
module lhm_alu (
  input  lhm_pkg::alu_op_e              op_i,
  input  logic [lhm_pkg::ALU_W-1:0]     a_i,
  input  logic [lhm_pkg::ALU_W-1:0]     b_i,
  input  logic [lhm_pkg::ALU_W-1:0]     mask_i,
  output lhm_pkg::alu_res_t             res_o
);
  import lhm_pkg::*;

  logic [ALU_W-1:0] b_eff;
  logic             carry_in;
  logic [ALU_W:0]   sum;
  logic             sat;

  // One adder serves both operations; a subtract adds the inverted operand.
  assign b_eff    = (op_i == ALU_SUB) ? ~b_i : b_i;
  assign carry_in = (op_i == ALU_SUB);
  assign sum      = {1'b0, a_i} + {1'b0, b_eff} + {{ALU_W{1'b0}}, carry_in};
  assign sat      = (sum > {1'b0, mask_i});

  always_comb begin
    res_o = '0;
    case (op_i)
      ALU_ADD: begin
        // Clamp the sum at the ceiling given by the mask.
        res_o.value = sat ? mask_i : sum[ALU_W-1:0];
        res_o.ge    = sat;
      end
      ALU_SUB: begin
        // Carry out of a + ~b + 1 means no borrow, so a >= b.
        res_o.value = sum[ALU_W-1:0];
        res_o.ge    = sum[ALU_W];
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

@@ rtl/lhm_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port memory with one write port and one registered read port.
module lhm_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read of the address being written returns the old data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/latency_histogram_monitor.sv @@
`timescale 1ns / 1ps
// Top level of the latency histogram monitor: sequencer, stores and result register.
//
// Request channel (in_valid_i / in_stall_o): a beat either records a duration
// for one counter or queries that counter's statistics. Result channel
// (out_valid_o / out_stall_i): one beat per query, none per record.
// A beat moves at a rising edge with valid high and stall low.
//
// All items run one at a time through a single shared adder/comparator, so
// in_stall_o stays high while an item is in work. A record searches for the
// log2 bucket the duration falls in (search steps one bucket a cycle), then
// updates bucket, count, total and maximum. A query forms count * percent by
// shift-add, then walks the histogram memory bucket by bucket (read, three
// shifted adds that scale the running sum by 100, compare) until the scaled
// sum reaches count * percent or the last bucket is done. A query of an empty
// counter leaves the multiply at its first step and skips the walk.
//
// After reset the block sweeps the histogram and statistics memories to zero,
// one entry a cycle over all 2^(CIW + BW) histogram addresses (256 with the
// defaults), with in_stall_o high. A finished result sits in the output
// register while out_stall_i is high; a new request is still taken, but a
// following query waits at its end until the register is free.
module latency_histogram_monitor #(
  parameter int unsigned NUM_COUNTERS = lhm_pkg::NUM_COUNTERS_DEF,
  parameter int unsigned NUM_BUCKETS  = lhm_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned COUNT_WIDTH  = lhm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [lhm_pkg::SEL_W-1:0]       counter_sel_i,
  input  logic [lhm_pkg::NS_W-1:0]        sample_ns_i,
  input  logic [lhm_pkg::PCT_W-1:0]       percent_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lhm_pkg::OUT_CNT_W-1:0]   sample_count_o,
  output logic [lhm_pkg::TOTAL_W-1:0]     duration_sum_o,
  output logic [lhm_pkg::MAX_W-1:0]       max_ns_o,
  output logic [lhm_pkg::PERC_W-1:0]      percentile_ns_o
);
  import lhm_pkg::*;

  // Derived sizes.
  localparam int unsigned CIW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam int unsigned BW  = $clog2(NUM_BUCKETS);
  localparam int unsigned HAW = CIW + BW;
  localparam int unsigned SW  = COUNT_WIDTH + TOTAL_W + MAX_W;
  localparam int unsigned PW  = COUNT_WIDTH + PCT_W;
  localparam int unsigned STW = $clog2(PW);

  localparam logic [ALU_W-1:0] ALU_ONES   = '1;
  localparam logic [ALU_W-1:0] CNT_MASK   =
    {{(ALU_W - COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
  localparam logic [ALU_W-1:0] TOTAL_MASK =
    {{(ALU_W - TOTAL_W){1'b0}}, {TOTAL_W{1'b1}}};
  localparam logic [BW-1:0]    LAST_BUCKET = BW'(NUM_BUCKETS - 1);
  localparam logic [STW-1:0]   MUL_LAST    = STW'(PCT_W - 1);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_STAT,
    S_LOAD,
    S_FIND,
    S_HINC,
    S_CNT,
    S_TOT,
    S_MAX,
    S_WSTAT,
    S_MUL,
    S_WRD,
    S_WACC,
    S_WACC2,
    S_WACC3,
    S_WCMP,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [HAW-1:0]          clr_q;
  logic                    req_q;
  logic [CIW-1:0]          c_q;
  logic [NS_W-1:0]         ns_q;
  logic [PCT_W-1:0]        pct_q;
  logic                    zero_q;
  logic [BW-1:0]           b_q;
  logic [STW-1:0]          step_q;
  logic [COUNT_WIDTH-1:0]  count_q;
  logic [TOTAL_W-1:0]      total_q;
  logic [MAX_W-1:0]        max_q;
  logic [PW-1:0]           acc_q;
  logic [ALU_W-1:0]        seen_q;
  logic [PERC_W-1:0]       perc_q;
  logic                    out_valid_q;
  logic [OUT_CNT_W-1:0]    sample_count_q;
  logic [TOTAL_W-1:0]      duration_sum_q;
  logic [MAX_W-1:0]        max_ns_q;
  logic [PERC_W-1:0]       percentile_ns_q;

  logic                    in_accept;
  logic                    in_range;
  logic [PCT_W-1:0]        pct_clamped;

  alu_op_e                 alu_op;
  logic [ALU_W-1:0]        alu_a;
  logic [ALU_W-1:0]        alu_b;
  logic [ALU_W-1:0]        alu_mask;
  alu_res_t                alu_res;

  logic                    hist_we;
  logic [HAW-1:0]          hist_waddr;
  logic [COUNT_WIDTH-1:0]  hist_wdata;
  logic [COUNT_WIDTH-1:0]  hist_rdata;
  logic                    stat_we;
  logic [CIW-1:0]          stat_waddr;
  logic [SW-1:0]           stat_wdata;
  logic [SW-1:0]           stat_rdata;

  // Request handshake and decode.
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_range    = (32'(counter_sel_i) < 32'(NUM_COUNTERS));
  assign pct_clamped = (percent_i > PCT_FULL) ? PCT_FULL : percent_i;

  // Shared arithmetic unit.
  lhm_alu u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .mask_i (alu_mask),
    .res_o  (alu_res)
  );

  // Histogram: one entry per counter and bucket, addressed as {counter, bucket}.
  lhm_ram #(
    .DATA_W (COUNT_WIDTH),
    .ADDR_W (HAW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i ({c_q, b_q}),
    .rdata_o (hist_rdata)
  );

  // Per-counter statistics word: {count, total, maximum}.
  lhm_ram #(
    .DATA_W (SW),
    .ADDR_W (CIW)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .waddr_i (stat_waddr),
    .wdata_i (stat_wdata),
    .raddr_i (c_q),
    .rdata_o (stat_rdata)
  );

  // Operand selection for the shared unit and memory write control.
  always_comb begin
    alu_op     = ALU_ADD;
    alu_a      = '0;
    alu_b      = '0;
    alu_mask   = ALU_ONES;
    hist_we    = 1'b0;
    hist_waddr = {c_q, b_q};
    hist_wdata = alu_res.value[COUNT_WIDTH-1:0];
    stat_we    = 1'b0;
    stat_waddr = c_q;
    stat_wdata = {count_q, total_q, max_q};
    case (state_q)
      S_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_q;
        hist_wdata = '0;
        stat_we    = (clr_q[BW-1:0] == '0);
        stat_waddr = clr_q[HAW-1:BW];
        stat_wdata = '0;
      end
      S_FIND: begin
        // Bucket test: 2^b >= duration.
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(1) << b_q;
        alu_b  = ALU_W'(ns_q);
      end
      S_HINC: begin
        alu_a    = ALU_W'(hist_rdata);
        alu_b    = ALU_W'(1);
        alu_mask = CNT_MASK;
        hist_we  = 1'b1;
      end
      S_CNT: begin
        alu_a    = ALU_W'(count_q);
        alu_b    = ALU_W'(1);
        alu_mask = CNT_MASK;
      end
      S_TOT: begin
        alu_a    = ALU_W'(total_q);
        alu_b    = ALU_W'(ns_q);
        alu_mask = TOTAL_MASK;
      end
      S_MAX: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(max_q);
        alu_b  = ALU_W'(ns_q);
      end
      S_WSTAT: begin
        stat_we = 1'b1;
      end
      S_MUL: begin
        alu_a = ALU_W'(acc_q);
        alu_b = ALU_W'(count_q) << step_q;
      end
      // The bucket count enters the scaled running sum as 64x, 32x and 4x.
      S_WACC: begin
        alu_a = seen_q;
        alu_b = ALU_W'(hist_rdata) << SCALE_SH0;
      end
      S_WACC2: begin
        alu_a = seen_q;
        alu_b = ALU_W'(hist_rdata) << SCALE_SH1;
      end
      S_WACC3: begin
        alu_a = seen_q;
        alu_b = ALU_W'(hist_rdata) << SCALE_SH2;
      end
      S_WCMP: begin
        alu_op = ALU_SUB;
        alu_a  = seen_q;
        alu_b  = ALU_W'(acc_q);
      end
      default: begin
      end
    endcase
  end

  // Sequencer with its working registers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLEAR;
      clr_q           <= '0;
      req_q           <= REQ_RECORD;
      c_q             <= '0;
      ns_q            <= '0;
      pct_q           <= '0;
      zero_q          <= 1'b0;
      b_q             <= '0;
      step_q          <= '0;
      count_q         <= '0;
      total_q         <= '0;
      max_q           <= '0;
      acc_q           <= '0;
      seen_q          <= '0;
      perc_q          <= '0;
      out_valid_q     <= 1'b0;
      sample_count_q  <= '0;
      duration_sum_q  <= '0;
      max_ns_q        <= '0;
      percentile_ns_q <= '0;
    end else begin
      // The result beat leaves when the receiver does not stall; a waiting
      // result takes its place at the same edge.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + HAW'(1);
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_accept) begin
            req_q  <= req_type_i;
            c_q    <= CIW'(counter_sel_i);
            ns_q   <= sample_ns_i;
            pct_q  <= pct_clamped;
            zero_q <= !in_range;
            if (in_range) begin
              state_q <= S_RD_STAT;
            end else if (req_type_i == REQ_QUERY) begin
              // Unknown counter: answer with an all-zero result.
              state_q <= S_DONE;
            end
          end
        end

        S_RD_STAT: begin
          state_q <= S_LOAD;
        end

        S_LOAD: begin
          count_q <= stat_rdata[SW-1 -: COUNT_WIDTH];
          total_q <= stat_rdata[TOTAL_W+MAX_W-1 -: TOTAL_W];
          max_q   <= stat_rdata[MAX_W-1:0];
          b_q     <= '0;
          step_q  <= '0;
          acc_q   <= '0;
          if (req_q == REQ_QUERY) begin
            state_q <= S_MUL;
          end else begin
            state_q <= S_FIND;
          end
        end

        // Record: find the bucket, then update bucket, count, total and max.
        S_FIND: begin
          if (alu_res.ge || (b_q == LAST_BUCKET)) begin
            state_q <= S_HINC;
          end else begin
            b_q <= b_q + BW'(1);
          end
        end

        S_HINC: begin
          state_q <= S_CNT;
        end

        S_CNT: begin
          count_q <= alu_res.value[COUNT_WIDTH-1:0];
          state_q <= S_TOT;
        end

        S_TOT: begin
          total_q <= alu_res.value[TOTAL_W-1:0];
          state_q <= S_MAX;
        end

        S_MAX: begin
          if (!alu_res.ge) begin
            max_q <= ns_q;
          end
          state_q <= S_WSTAT;
        end

        S_WSTAT: begin
          state_q <= S_IDLE;
        end

        // Query: count * percent by shift-add, one percent bit a cycle.
        S_MUL: begin
          if (count_q == '0) begin
            perc_q  <= '0;
            state_q <= S_DONE;
          end else begin
            if (pct_q[0]) begin
              acc_q <= alu_res.value[PW-1:0];
            end
            pct_q  <= pct_q >> 1;
            step_q <= step_q + STW'(1);
            if (step_q == MUL_LAST) begin
              seen_q  <= '0;
              state_q <= S_WRD;
            end
          end
        end

        // Bucket walk: read, accumulate 100 times the count, compare.
        S_WRD: begin
          state_q <= S_WACC;
        end

        S_WACC: begin
          seen_q  <= alu_res.value;
          state_q <= S_WACC2;
        end

        S_WACC2: begin
          seen_q  <= alu_res.value;
          state_q <= S_WACC3;
        end

        S_WACC3: begin
          seen_q  <= alu_res.value;
          state_q <= S_WCMP;
        end

        // A nonzero sum is needed too, so a zero percent finds the first
        // non-empty bucket.
        S_WCMP: begin
          if (alu_res.ge && (seen_q != '0)) begin
            perc_q  <= PERC_W'(1) << b_q;
            state_q <= S_DONE;
          end else if (b_q == LAST_BUCKET) begin
            perc_q  <= '0;
            state_q <= S_DONE;
          end else begin
            b_q     <= b_q + BW'(1);
            state_q <= S_WRD;
          end
        end

        // Load the result register once it is free.
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            if (zero_q) begin
              sample_count_q  <= '0;
              duration_sum_q  <= '0;
              max_ns_q        <= '0;
              percentile_ns_q <= '0;
            end else begin
              sample_count_q  <= OUT_CNT_W'(count_q);
              duration_sum_q  <= total_q;
              max_ns_q        <= max_q;
              percentile_ns_q <= perc_q;
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_count_o  = sample_count_q;
  assign duration_sum_o  = duration_sum_q;
  assign max_ns_o        = max_ns_q;
  assign percentile_ns_o = percentile_ns_q;

endmodule

@@ rtl/lhm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the latency histogram monitor and their bind to the top level.
module lhm_checker #(
  parameter int unsigned COUNT_WIDTH = lhm_pkg::COUNT_WIDTH_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            req_type_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [lhm_pkg::OUT_CNT_W-1:0]   sample_count_o,
  input logic [lhm_pkg::TOTAL_W-1:0]     duration_sum_o,
  input logic [lhm_pkg::MAX_W-1:0]       max_ns_o,
  input logic [lhm_pkg::PERC_W-1:0]      percentile_ns_o
);
  import lhm_pkg::*;

  // A query always keeps the block busy for at least the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (req_type_i == REQ_QUERY)) |=> in_stall_o)
    else $error("request taken right after a query beat");

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(percentile_ns_o) && $stable(duration_sum_o)))
    else $error("stalled result beat changed");

  // A percentile is zero or a single power of two.
  a_perc_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(percentile_ns_o))
    else $error("percentile is not a bucket bound");

  // The saturating total never falls below the largest sample.
  a_total_ge_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duration_sum_o >= TOTAL_W'(max_ns_o)))
    else $error("total below maximum");

  // An empty counter reports no total, maximum or percentile.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (COUNT_WIDTH <= OUT_CNT_W) && (sample_count_o == '0)) |->
      ((duration_sum_o == '0) && (max_ns_o == '0) && (percentile_ns_o == '0)))
    else $error("empty counter with nonzero statistics");

endmodule

bind latency_histogram_monitor lhm_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_lhm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .req_type_i      (req_type_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .sample_count_o  (sample_count_o),
  .duration_sum_o  (duration_sum_o),
  .max_ns_o        (max_ns_o),
  .percentile_ns_o (percentile_ns_o)
);
